>>> rtl/tpss_pkg.sv
package tpss_pkg;

  // Width of every key on the result ports.
  localparam int unsigned KeyBits   = 48;
  // Width of the key scale register.
  localparam int unsigned ScaleBits = 20;
  // Width of the configuration data bus.
  localparam int unsigned RegBits   = 32;
  // Edges of one triangle, tested in the order 0-1, 1-2, 2-0.
  localparam int unsigned NumEdges  = 3;

  localparam logic [ScaleBits-1:0] ScaleReset = 20'd1000;

  typedef enum logic {
    REG_SLICE_HEIGHT = 1'b0,
    REG_KEY_SCALE    = 1'b1
  } reg_idx_e;

  // Control that travels with one classified triangle.
  typedef struct packed {
    logic                valid;
    logic [NumEdges-1:0] hit;
  } edge_ctl_t;

endpackage

>>> rtl/tpss_front.sv
module tpss_front import tpss_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  output logic                                       busy_o,
  input  logic signed [COORD_WIDTH-1:0]              height_i,
  input  logic signed [COORD_WIDTH-1:0]              vx_i [NumEdges],
  input  logic signed [COORD_WIDTH-1:0]              vy_i [NumEdges],
  input  logic signed [COORD_WIDTH-1:0]              vz_i [NumEdges],
  input  logic                                       q_ready_i,
  output edge_ctl_t                                  ctl_o,
  output logic [NumEdges*(6*COORD_WIDTH+4)-1:0]      data_o
);

  localparam int unsigned DW    = COORD_WIDTH + 1;
  localparam int unsigned EdgeW = 2 * COORD_WIDTH + 4 * DW;

  logic                          vld_q, vld_d;
  logic [NumEdges-1:0]           hit_q, hit_d;
  logic [NumEdges*EdgeW-1:0]     data_q, data_d;
  logic                          accept;

  assign busy_o = vld_q && !q_ready_i;
  assign accept = start_i && !busy_o;

  always_comb begin
    int nx;
    logic inplane;
    logic signed [DW-1:0] s_v, dpx_v, dpy_v, dz_v;
    nx      = 0;
    inplane = 1'b0;
    s_v     = '0;
    dpx_v   = '0;
    dpy_v   = '0;
    dz_v    = '0;
    hit_d   = '0;
    data_d  = '0;
    for (int e = 0; e < NumEdges; e++) begin
      nx      = (e == NumEdges - 1) ? 0 : e + 1;
      inplane = (vz_i[e] == height_i) && (vz_i[nx] == height_i);
      hit_d[e] = !((vz_i[e] > height_i) && (vz_i[nx] > height_i)) &&
                 !((vz_i[e] < height_i) && (vz_i[nx] < height_i)) &&
                 (!inplane || ((vx_i[e] == vx_i[nx]) && (vy_i[e] == vy_i[nx])));
      if (inplane) begin
        // A degenerate edge in the plane gives its first vertex exactly.
        s_v   = '0;
        dpx_v = '0;
        dpy_v = '0;
        dz_v  = DW'(1);
      end else begin
        s_v   = DW'(height_i) - DW'(vz_i[e]);
        dpx_v = DW'(vx_i[nx]) - DW'(vx_i[e]);
        dpy_v = DW'(vy_i[nx]) - DW'(vy_i[e]);
        dz_v  = DW'(vz_i[nx]) - DW'(vz_i[e]);
      end
      data_d[e*EdgeW +: EdgeW] = {vx_i[e], vy_i[e], s_v, dpx_v, dpy_v, dz_v};
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (q_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q  <= hit_d;
      data_q <= data_d;
    end
  end

  assign ctl_o.valid = vld_q;
  assign ctl_o.hit   = hit_q;
  assign data_o      = data_q;

endmodule

>>> rtl/tpss_queue.sv
module tpss_queue import tpss_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  // Two entries; the back end drains one entry every cycle it has one.
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign do_push = push_i && ready_o;
  assign do_pop  = valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/tpss_key.sv
module tpss_key import tpss_pkg::*; #(
  parameter int unsigned COORD_WIDTH     = 32,
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ScaleBits-1:0]          scale_i,
  input  logic                          vld_i,
  input  logic                          hit_i,
  input  logic signed [COORD_WIDTH-1:0] p_i,
  input  logic signed [COORD_WIDTH:0]   s_i,
  input  logic signed [COORD_WIDTH:0]   dp_i,
  input  logic signed [COORD_WIDTH:0]   dz_i,
  output logic                          vld_o,
  output logic                          hit_o,
  output logic signed [KeyBits-1:0]     key_o
);

  localparam int unsigned DW   = COORD_WIDTH + 1;
  localparam int unsigned PAW  = COORD_WIDTH + DW;
  localparam int unsigned PBW  = 2 * DW;
  localparam int unsigned NW   = 2 * COORD_WIDTH + 3;
  localparam int unsigned LoW  = NW / 2;
  localparam int unsigned HiW  = NW - LoW;
  localparam int unsigned SCW  = NW + ScaleBits + 1;
  localparam int unsigned QW   = KeyBits + COORD_FRAC_BITS + 1;
  localparam int unsigned SXW  = (SCW > QW) ? SCW : QW + 1;
  localparam int unsigned TW   = SXW - QW;
  localparam int unsigned CMPW = (TW > DW) ? TW : DW;
  localparam logic [QW:0]      RndBias = (QW + 1)'(1) << COORD_FRAC_BITS;
  localparam logic [KeyBits:0] KeyTop  = (KeyBits + 1)'(1) << (KeyBits - 1);

  // Products.
  logic                  v1_q, h1_q;
  logic signed [PAW-1:0] pa_q;
  logic signed [PBW-1:0] pb_q;
  logic signed [DW-1:0]  dz1_q;
  // Magnitudes.
  logic                  v2_q, h2_q, neg2_q;
  logic [NW-1:0]         mag2_q;
  logic [DW-1:0]         ad2_q;
  logic signed [NW-1:0]  n_sum;
  // Scaling partial products.
  logic                      v3_q, h3_q, neg3_q;
  logic [LoW+ScaleBits-1:0]  plo_q;
  logic [HiW+ScaleBits-1:0]  phi_q;
  logic [DW-1:0]             ad3_q;
  logic [SXW-1:0]            sc;
  logic [CMPW-1:0]           top_ext;
  // Divider stages.
  logic            dv_vld_q [QW+1];
  logic            dv_hit_q [QW+1];
  logic            dv_neg_q [QW+1];
  logic            dv_ovf_q [QW+1];
  logic [DW-1:0]   dv_ad_q  [QW+1];
  logic [DW-1:0]   dv_rem_q [QW+1];
  logic [QW-1:0]   dv_num_q [QW+1];
  logic [QW-1:0]   dv_quo_q [QW+1];
  // Output.
  logic                   vo_q, ho_q;
  logic signed [KeyBits-1:0] key_q, key_d;
  logic [QW:0]            rnd;
  logic [KeyBits:0]       kmag, lim, sat;

  assign n_sum   = NW'(pa_q) + NW'(pb_q);
  assign sc      = ((SXW'(phi_q) << LoW) + SXW'(plo_q)) << 1;
  assign top_ext = CMPW'(sc[SXW-1:QW]);

  always_comb begin
    rnd  = {1'b0, dv_quo_q[QW]} + RndBias;
    kmag = rnd[QW:COORD_FRAC_BITS+1];
    lim  = dv_neg_q[QW] ? KeyTop : KeyTop - (KeyBits + 1)'(1);
    sat  = (dv_ovf_q[QW] || (kmag > lim)) ? lim : kmag;
    key_d = dv_neg_q[QW] ? -$signed(sat[KeyBits-1:0]) : $signed(sat[KeyBits-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
      for (int k = 0; k <= QW; k++) begin
        dv_vld_q[k] <= 1'b0;
      end
    end else begin
      v1_q        <= vld_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      dv_vld_q[0] <= v3_q;
      for (int k = 1; k <= QW; k++) begin
        dv_vld_q[k] <= dv_vld_q[k-1];
      end
      vo_q <= dv_vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [DW:0] trial;
    logic        ge;
    trial = '0;
    ge    = 1'b0;
    h1_q  <= hit_i;
    pa_q  <= p_i * dz_i;
    pb_q  <= s_i * dp_i;
    dz1_q <= dz_i;

    h2_q   <= h1_q;
    neg2_q <= n_sum[NW-1] ^ dz1_q[DW-1];
    mag2_q <= n_sum[NW-1] ? NW'(-n_sum) : NW'(n_sum);
    ad2_q  <= dz1_q[DW-1] ? DW'(-dz1_q) : DW'(dz1_q);

    h3_q   <= h2_q;
    neg3_q <= neg2_q;
    ad3_q  <= ad2_q;
    plo_q  <= mag2_q[LoW-1:0] * scale_i;
    phi_q  <= mag2_q[NW-1:LoW] * scale_i;

    // The part of the numerator above the quotient bits decides saturation.
    dv_hit_q[0] <= h3_q;
    dv_neg_q[0] <= neg3_q;
    dv_ad_q[0]  <= ad3_q;
    dv_ovf_q[0] <= top_ext >= CMPW'(ad3_q);
    dv_rem_q[0] <= top_ext[DW-1:0];
    dv_num_q[0] <= sc[QW-1:0];
    dv_quo_q[0] <= '0;

    // One restoring quotient bit per stage.
    for (int k = 1; k <= QW; k++) begin
      trial = {dv_rem_q[k-1], dv_num_q[k-1][QW-1]};
      ge    = trial >= {1'b0, dv_ad_q[k-1]};
      dv_rem_q[k] <= ge ? DW'(trial - {1'b0, dv_ad_q[k-1]}) : DW'(trial);
      dv_num_q[k] <= dv_num_q[k-1] << 1;
      dv_quo_q[k] <= {dv_quo_q[k-1][QW-2:0], ge};
      dv_hit_q[k] <= dv_hit_q[k-1];
      dv_neg_q[k] <= dv_neg_q[k-1];
      dv_ovf_q[k] <= dv_ovf_q[k-1];
      dv_ad_q[k]  <= dv_ad_q[k-1];
    end

    ho_q  <= dv_hit_q[QW];
    key_q <= key_d;
  end

  assign vld_o = vo_q;
  assign hit_o = ho_q;
  assign key_o = key_q;

endmodule

>>> rtl/tpss_back.sv
module tpss_back import tpss_pkg::*; #(
  parameter int unsigned COORD_WIDTH     = 32,
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [ScaleBits-1:0]                  scale_i,
  input  edge_ctl_t                             ctl_i,
  input  logic [NumEdges*(6*COORD_WIDTH+4)-1:0] data_i,
  output logic                                  res_vld_o,
  output logic signed [KeyBits-1:0]             start_x_o,
  output logic signed [KeyBits-1:0]             start_y_o,
  output logic signed [KeyBits-1:0]             end_x_o,
  output logic signed [KeyBits-1:0]             end_y_o
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned DW    = COORD_WIDTH + 1;
  localparam int unsigned EdgeW = 2 * CW + 4 * DW;

  logic                      vx_w [NumEdges];
  logic                      vy_w [NumEdges];
  logic                      hx_w [NumEdges];
  logic                      hy_w [NumEdges];
  logic signed [KeyBits-1:0] kx   [NumEdges];
  logic signed [KeyBits-1:0] ky   [NumEdges];

  for (genvar e = 0; e < NumEdges; e++) begin : g_edge
    localparam int unsigned Base = e * EdgeW;

    tpss_key #(
      .COORD_WIDTH    (COORD_WIDTH),
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_key_x (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .scale_i(scale_i),
      .vld_i  (ctl_i.valid),
      .hit_i  (ctl_i.hit[e]),
      .p_i    (data_i[Base+4*DW+CW +: CW]),
      .s_i    (data_i[Base+3*DW +: DW]),
      .dp_i   (data_i[Base+2*DW +: DW]),
      .dz_i   (data_i[Base +: DW]),
      .vld_o  (vx_w[e]),
      .hit_o  (hx_w[e]),
      .key_o  (kx[e])
    );

    tpss_key #(
      .COORD_WIDTH    (COORD_WIDTH),
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_key_y (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .scale_i(scale_i),
      .vld_i  (ctl_i.valid),
      .hit_i  (ctl_i.hit[e]),
      .p_i    (data_i[Base+4*DW +: CW]),
      .s_i    (data_i[Base+3*DW +: DW]),
      .dp_i   (data_i[Base+DW +: DW]),
      .dz_i   (data_i[Base +: DW]),
      .vld_o  (vy_w[e]),
      .hit_o  (hy_w[e]),
      .key_o  (ky[e])
    );
  end

  logic       vld_all, e0, e1, e2, d1, d2;
  logic [1:0] cnt;
  logic       res_vld_q;
  logic signed [KeyBits-1:0] sx_q, sy_q, ex_q, ey_q;

  always_comb begin
    vld_all = 1'b1;
    for (int e = 0; e < NumEdges; e++) begin
      vld_all = vld_all && vx_w[e] && vy_w[e];
    end
    e0 = hx_w[0] && hy_w[0];
    e1 = hx_w[1] && hy_w[1];
    e2 = hx_w[2] && hy_w[2];
    d1 = e1 && !(e0 && (kx[1] == kx[0]) && (ky[1] == ky[0]));
    d2 = e2 && !(e0 && (kx[2] == kx[0]) && (ky[2] == ky[0]))
            && !(e1 && (kx[2] == kx[1]) && (ky[2] == ky[1]));
    cnt = 2'(e0) + 2'(d1) + 2'(d2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= vld_all && (cnt == 2'd2);
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q <= e0 ? kx[0] : kx[1];
    sy_q <= e0 ? ky[0] : ky[1];
    ex_q <= (e0 && d1) ? kx[1] : kx[2];
    ey_q <= (e0 && d1) ? ky[1] : ky[2];
  end

  assign res_vld_o = res_vld_q;
  assign start_x_o = sx_q;
  assign start_y_o = sy_q;
  assign end_x_o   = ex_q;
  assign end_y_o   = ey_q;

endmodule

>>> rtl/triangle_plane_slice_segment.sv
// Channel       | Direction | Handshake                      | Payload
// --------------+-----------+--------------------------------+--------------------------------
// triangle      | in        | start && !busy                 | ax_i .. cz_i, Q16.16 vertices
// segment       | out       | result_valid_o, one cycle      | start_key_*_o, end_key_*_o
// configuration | in / out  | APB write when psel & penable  | slice_height, key_scale
//
// A triangle is accepted every cycle; busy only rises if the queue between the front and
// back ends were to fill, which the back end never allows since it drains every cycle.
// Each accepted triangle passes the front register, the queue, the key pipelines with their
// one-bit-per-stage divider, and the back end output register before its segment appears.
// Reset clears the valid flags of every stage and restores the configuration registers.
// Results cannot be held off by the receiver; each one is shown for exactly one cycle.
module triangle_plane_slice_segment import tpss_pkg::*; #(
  parameter int unsigned COORD_WIDTH     = 32,
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [RegBits-1:0]            pwdata,
  output logic [RegBits-1:0]            prdata,
  output logic                          pready,
  // Triangle transactions.
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] az_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  input  logic signed [COORD_WIDTH-1:0] bz_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] cz_i,
  // Segment transactions.
  output logic                          result_valid_o,
  output logic signed [KeyBits-1:0]     start_key_x_o,
  output logic signed [KeyBits-1:0]     start_key_y_o,
  output logic signed [KeyBits-1:0]     end_key_x_o,
  output logic signed [KeyBits-1:0]     end_key_y_o
);

  localparam int unsigned DataW = NumEdges * (6 * COORD_WIDTH + 4);

  // Configuration registers. The height register holds the written word; the plane
  // height is its low COORD_WIDTH bits taken as a two's complement value.
  logic [RegBits-1:0]   slice_height_q;
  logic [ScaleBits-1:0] key_scale_q;
  logic                 cfg_wr;
  reg_idx_e             cfg_idx;
  logic [2*RegBits-1:0] height_wide;
  logic signed [COORD_WIDTH-1:0] height;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;
  assign cfg_idx     = reg_idx_e'(paddr[2]);
  assign height_wide = {{RegBits{1'b0}}, slice_height_q};
  assign height      = height_wide[COORD_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_height_q <= '0;
      key_scale_q    <= ScaleReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SLICE_HEIGHT: slice_height_q <= pwdata;
        REG_KEY_SCALE:    key_scale_q    <= pwdata[ScaleBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SLICE_HEIGHT: prdata = slice_height_q;
      REG_KEY_SCALE:    prdata = RegBits'(key_scale_q);
      default:          prdata = '0;
    endcase
  end

  // Front end: registers the triangle and classifies each edge against the plane.
  logic signed [COORD_WIDTH-1:0] vx [NumEdges];
  logic signed [COORD_WIDTH-1:0] vy [NumEdges];
  logic signed [COORD_WIDTH-1:0] vz [NumEdges];

  assign vx[0] = ax_i;
  assign vx[1] = bx_i;
  assign vx[2] = cx_i;
  assign vy[0] = ay_i;
  assign vy[1] = by_i;
  assign vy[2] = cy_i;
  assign vz[0] = az_i;
  assign vz[1] = bz_i;
  assign vz[2] = cz_i;

  edge_ctl_t            front_ctl;
  logic [DataW-1:0]     front_data;
  logic                 q_ready;

  tpss_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .height_i (height),
    .vx_i     (vx),
    .vy_i     (vy),
    .vz_i     (vz),
    .q_ready_i(q_ready),
    .ctl_o    (front_ctl),
    .data_o   (front_data)
  );

  // Short queue between the two ends; the edge hit flags travel with the data.
  logic                      q_valid;
  logic [NumEdges+DataW-1:0] q_data;
  edge_ctl_t                 back_ctl;

  tpss_queue #(
    .WIDTH(NumEdges + DataW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_ctl.valid),
    .data_i ({front_ctl.hit, front_data}),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .data_o (q_data)
  );

  assign back_ctl.valid = q_valid;
  assign back_ctl.hit   = q_data[NumEdges+DataW-1:DataW];

  // Back end: interpolation, scaling, division, rounding and duplicate removal.
  tpss_back #(
    .COORD_WIDTH    (COORD_WIDTH),
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .scale_i  (key_scale_q),
    .ctl_i    (back_ctl),
    .data_i   (q_data[DataW-1:0]),
    .res_vld_o(result_valid_o),
    .start_x_o(start_key_x_o),
    .start_y_o(start_key_y_o),
    .end_x_o  (end_key_x_o),
    .end_y_o  (end_key_y_o)
  );

endmodule
